@@ hw/rtl/bsrch_pkg.sv @@
// shared constants for the sorted table binary search block
package bsrch_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // fixed field widths of the ports
  localparam int LEN_W = 11;
  localparam int POS_W = 10;
  localparam int VAL_W = 32;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

endpackage

@@ hw/rtl/bsrch_ram.sv @@
// simple dual port ram, one write port and one registered read port
module bsrch_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sorted_table_binary_search.sv @@
// top level: entry table with an iterative binary search over it
// a write item goes to the ram when it is accepted; a search runs probes, each a ram read
// and then a compare, at most clog2(len)+1 of them, and then hands the result to the
// output register, where it waits while the output is stalled
// the table read port of the ram sets the probe rate; one item is worked on at a time
// reset clears list_length and the control state; table contents stay undefined until written
module sorted_table_binary_search
  import bsrch_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_list_length_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             in_func_i,
  input  logic [POS_W-1:0] in_position_i,
  input  logic [VAL_W-1:0] in_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             out_found_o,
  output logic [POS_W-1:0] out_match_position_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [LEN_W-1:0]     list_length_q, list_length_d;
  logic [LEN_W-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic                 res_found_q, res_found_d;
  logic [LEN_W-1:0]     res_pos_q, res_pos_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q, out_found_d;
  logic [POS_W-1:0]     out_pos_q, out_pos_d;

  logic                 in_accept;
  logic                 out_free;
  logic [LEN_W-1:0]     len_eff;
  logic [LEN_W:0]       mid_sum;
  logic                 ram_we, ram_re;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // a length beyond the table depth saturates
  assign len_eff = (32'(list_length_q) > 32'(DEPTH)) ? LEN_W'(DEPTH) : list_length_q;

  // floor((lo + hi - 1) / 2), only used while lo < hi
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (LEN_W + 1)'(1);

  assign ram_we = in_accept && (in_func_i == FUNC_WRITE) && (32'(in_position_i) < 32'(DEPTH));
  assign ram_re = (state_q == S_PROBE) && (lo_q < hi_q);

  bsrch_ram #(
    .AW (ADDR_W),
    .DW (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ADDR_W'(in_position_i)),
    .wdata_i (DATA_WIDTH'(in_value_i)),
    .re_i    (ram_re),
    .raddr_i (ADDR_W'(mid_sum[LEN_W:1])),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    list_length_d = list_length_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    key_d         = key_q;
    res_found_d   = res_found_q;
    res_pos_d     = res_pos_q;
    out_valid_d   = out_valid_q;
    out_found_d   = out_found_q;
    out_pos_d     = out_pos_q;

    if (cfg_valid_i && cfg_ready_o) begin
      list_length_d = cfg_list_length_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept && (in_func_i == FUNC_SEARCH)) begin
          lo_d    = '0;
          hi_d    = len_eff;
          key_d   = DATA_WIDTH'(in_value_i);
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_sum[LEN_W:1];
          state_d = S_CMP;
        end else begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = S_DONE;
        end
      end
      S_CMP: begin
        if (ram_rdata < key_q) begin
          lo_d    = mid_q + LEN_W'(1);
          state_d = S_PROBE;
        end else if (ram_rdata > key_q) begin
          hi_d    = mid_q;
          state_d = S_PROBE;
        end else begin
          res_found_d = 1'b1;
          res_pos_d   = mid_q;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_pos_d   = res_pos_q[POS_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      list_length_q <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      mid_q         <= '0;
      key_q         <= '0;
      res_found_q   <= 1'b0;
      res_pos_q     <= '0;
      out_valid_q   <= 1'b0;
      out_found_q   <= 1'b0;
      out_pos_q     <= '0;
    end else begin
      state_q       <= state_d;
      list_length_q <= list_length_d;
      lo_q          <= lo_d;
      hi_q          <= hi_d;
      mid_q         <= mid_d;
      key_q         <= key_d;
      res_found_q   <= res_found_d;
      res_pos_q     <= res_pos_d;
      out_valid_q   <= out_valid_d;
      out_found_q   <= out_found_d;
      out_pos_q     <= out_pos_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_found_o          = out_found_q;
  assign out_match_position_o = out_pos_q;

  // window never inverts while a search runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE || state_q == S_CMP) |-> (lo_q <= hi_q))
    else $error("search window inverted");

  // window stays inside the table in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE || state_q == S_CMP) |-> (hi_q <= len_eff))
    else $error("search window beyond list length");

  // a hit always lies inside the table in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_found_q) |-> (res_pos_q < len_eff))
    else $error("match position beyond list length");

  // a miss reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_found_o) |-> (out_match_position_o == '0))
    else $error("miss with nonzero position");

  // a result is only loaded from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && $past(state_q) != S_DONE) |=> !out_valid_q || $past(state_q == S_DONE))
    else $error("result appeared without a finished search");

endmodule
